@@ src/spq_pkg.sv @@
// ----------------------------------------------------------------------------
// Sorted priority queue package
// Shared widths, codes and the entry record for the sorted priority queue.
// ----------------------------------------------------------------------------
package spq_pkg;

  // Fixed field widths of the stream items.
  localparam int unsigned PRIORITY_BITS = 8;
  localparam int unsigned ID_BITS       = 16;
  localparam int unsigned OPCODE_BITS   = 2;
  localparam int unsigned STATUS_BITS   = 2;

  // Default queue depth.
  localparam int unsigned QUEUE_DEPTH_DEFAULT = 16;

  // Packed stream widths, rounded up to whole bytes.
  localparam int unsigned IN_BITS   = OPCODE_BITS + PRIORITY_BITS + ID_BITS;
  localparam int unsigned IN_WIDTH  = ((IN_BITS + 7) / 8) * 8;
  localparam int unsigned OUT_BITS  = STATUS_BITS + ID_BITS + PRIORITY_BITS;
  localparam int unsigned OUT_WIDTH = ((OUT_BITS + 7) / 8) * 8;

  typedef enum logic [OPCODE_BITS-1:0] {
    OP_INSERT = 2'd0,
    OP_POP    = 2'd1,
    OP_REMOVE = 2'd2
  } opcode_e;

  typedef enum logic [STATUS_BITS-1:0] {
    ST_OK        = 2'd0,
    ST_EMPTY     = 2'd1,
    ST_NOT_FOUND = 2'd2,
    ST_FULL      = 2'd3
  } status_e;

  // One stored queue entry.
  typedef struct packed {
    logic [ID_BITS-1:0]       id;
    logic [PRIORITY_BITS-1:0] prio;
  } entry_t;

endpackage

@@ src/spq_entry_ram.sv @@
// ----------------------------------------------------------------------------
// Sorted priority queue entry RAM
// Simple dual-port entry store: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module spq_entry_ram #(
  parameter int unsigned DEPTH = spq_pkg::QUEUE_DEPTH_DEFAULT,
  localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  spq_pkg::entry_t  wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output spq_pkg::entry_t  rdata_o
);

  spq_pkg::entry_t mem_q [DEPTH];
  spq_pkg::entry_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ src/sorted_priority_queue_with_remove.sv @@
// ----------------------------------------------------------------------------
// Sorted priority queue with remove
// Bounded priority queue kept in descending priority order, FIFO among equals.
// ----------------------------------------------------------------------------
// The queue holds up to QUEUE_DEPTH entries in a single RAM, kept sorted with
// the head at address 0. Each command is one transfer on the slave stream and
// yields exactly one transfer on the master stream. Insert gives the entry the
// next sequential id (1 upward, wrapping back to 1) and returns it; a full
// queue drops the insert and reports full without using an id. Pop returns the
// head or reports empty; remove-by-id takes out the match nearest the head or
// reports not found. All work runs through the one RAM read port and one
// compare, one entry per cycle: an insert into an empty queue writes the head
// at once, an insert into a non-empty queue reads from the tail and moves each
// lower-priority entry back behind the new one, a pop or remove reads every
// stored entry, and commands that touch no entry (opcode 3, full, empty) go
// straight to the result stage. The slave side is ready only while no command
// is in progress; a finished result sits in an output register, so the next
// command is taken while it waits to be read. If that next result is done
// before the previous one is read, the command holds in its last cycle until the output frees up.
// ----------------------------------------------------------------------------
module sorted_priority_queue_with_remove #(
  parameter int unsigned QUEUE_DEPTH = spq_pkg::QUEUE_DEPTH_DEFAULT
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // Command stream. tdata from bit 0: opcode[1:0], priority_req[9:2],
  // target_id[25:10], zero padding.
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [spq_pkg::IN_WIDTH-1:0]  s_axis_tdata,
  // Result stream. tdata from bit 0: status[1:0], out_id[17:2],
  // out_priority[25:18], zero padding.
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  output logic [spq_pkg::OUT_WIDTH-1:0] m_axis_tdata
);

  localparam int unsigned AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned CW = $clog2(QUEUE_DEPTH + 1);
  localparam int unsigned PB = spq_pkg::PRIORITY_BITS;
  localparam int unsigned IB = spq_pkg::ID_BITS;
  localparam int unsigned OB = spq_pkg::OPCODE_BITS;
  localparam int unsigned SB = spq_pkg::STATUS_BITS;
  localparam int unsigned PAD_BITS = spq_pkg::OUT_WIDTH - spq_pkg::OUT_BITS;

  // Sequencer states. INS walks from the tail toward the head, shifting each
  // lower-priority entry back by one; DEL walks from the head, closing the gap
  // behind the removed entry.
  typedef enum logic [2:0] {
    S_IDLE,
    S_INS,
    S_INS_HEAD,
    S_DEL,
    S_RESULT
  } state_e;

  state_e              state_q, state_d;
  logic [CW-1:0]       count_q, count_d;
  logic [IB-1:0]       next_id_q, next_id_d;
  logic [AW-1:0]       idx_q, idx_d;
  logic                found_q, found_d;
  logic                is_pop_q, is_pop_d;
  logic [PB-1:0]       prio_q, prio_d;
  logic [IB-1:0]       tid_q, tid_d;
  spq_pkg::status_e    res_status_q, res_status_d;
  logic [IB-1:0]       res_id_q, res_id_d;
  logic [PB-1:0]       res_prio_q, res_prio_d;
  logic                m_valid_q, m_valid_d;
  spq_pkg::status_e    m_status_q, m_status_d;
  logic [IB-1:0]       m_id_q, m_id_d;
  logic [PB-1:0]       m_prio_q, m_prio_d;

  // RAM port controls.
  logic                ram_we;
  logic [AW-1:0]       ram_waddr;
  spq_pkg::entry_t     ram_wdata;
  logic                ram_re;
  logic [AW-1:0]       ram_raddr;
  spq_pkg::entry_t     ram_rdata;

  // Unpacked command fields.
  spq_pkg::opcode_e    in_op;
  logic [PB-1:0]       in_prio;
  logic [IB-1:0]       in_tid;
  logic                s_fire;

  // Helpers used by the sequencer.
  spq_pkg::entry_t     new_entry;
  logic [IB-1:0]       id_after;
  logic [AW-1:0]       last_idx;
  logic                id_match;

  assign in_op   = spq_pkg::opcode_e'(s_axis_tdata[OB-1:0]);
  assign in_prio = s_axis_tdata[OB +: PB];
  assign in_tid  = s_axis_tdata[OB+PB +: IB];

  assign s_axis_tready = (state_q == S_IDLE);
  assign s_fire        = s_axis_tvalid && s_axis_tready;

  assign new_entry = '{id: next_id_q, prio: prio_q};
  assign id_after  = (next_id_q == {IB{1'b1}}) ? IB'(1) : next_id_q + IB'(1);
  assign last_idx  = AW'(count_q - CW'(1));
  // A pop matches the head; a remove matches the first entry with its id.
  assign id_match  = is_pop_q ? (idx_q == '0) : (ram_rdata.id == tid_q);

  spq_entry_ram #(
    .DEPTH (QUEUE_DEPTH)
  ) u_entry_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  always_comb begin
    state_d      = state_q;
    count_d      = count_q;
    next_id_d    = next_id_q;
    idx_d        = idx_q;
    found_d      = found_q;
    is_pop_d     = is_pop_q;
    prio_d       = prio_q;
    tid_d        = tid_q;
    res_status_d = res_status_q;
    res_id_d     = res_id_q;
    res_prio_d   = res_prio_q;
    m_valid_d    = m_valid_q;
    m_status_d   = m_status_q;
    m_id_d       = m_id_q;
    m_prio_d     = m_prio_q;

    ram_we    = 1'b0;
    ram_waddr = '0;
    ram_wdata = new_entry;
    ram_re    = 1'b0;
    ram_raddr = '0;

    // The downstream side drains the output register independently.
    if (m_valid_q && m_axis_tready) begin
      m_valid_d = 1'b0;
    end

    unique case (state_q)
      S_IDLE: begin
        if (s_fire) begin
          prio_d       = in_prio;
          tid_d        = in_tid;
          found_d      = 1'b0;
          res_status_d = spq_pkg::ST_OK;
          res_id_d     = '0;
          res_prio_d   = '0;
          state_d      = S_RESULT;
          case (in_op) inside
            spq_pkg::OP_INSERT: begin
              if (count_q == CW'(QUEUE_DEPTH)) begin
                res_status_d = spq_pkg::ST_FULL;
              end else if (count_q == '0) begin
                // Empty queue: the new entry becomes the head right away.
                ram_we       = 1'b1;
                ram_waddr    = '0;
                ram_wdata    = '{id: next_id_q, prio: in_prio};
                count_d      = count_q + CW'(1);
                next_id_d    = id_after;
                res_id_d     = next_id_q;
                res_prio_d   = in_prio;
              end else begin
                ram_re    = 1'b1;
                ram_raddr = last_idx;
                idx_d     = last_idx;
                state_d   = S_INS;
              end
            end
            spq_pkg::OP_POP, spq_pkg::OP_REMOVE: begin
              is_pop_d = (in_op == spq_pkg::OP_POP);
              if (count_q == '0) begin
                res_status_d = (in_op == spq_pkg::OP_POP) ? spq_pkg::ST_EMPTY
                                                          : spq_pkg::ST_NOT_FOUND;
              end else begin
                ram_re    = 1'b1;
                ram_raddr = '0;
                idx_d     = '0;
                state_d   = S_DEL;
              end
            end
            default: begin
              // Unused opcode: empty OK result, no state change.
            end
          endcase
        end
      end

      S_INS: begin
        ram_we    = 1'b1;
        ram_waddr = idx_q + AW'(1);
        if (ram_rdata.prio >= prio_q) begin
          // New entry lands right behind every entry of equal or higher priority.
          ram_wdata  = new_entry;
          count_d    = count_q + CW'(1);
          next_id_d  = id_after;
          res_id_d   = next_id_q;
          res_prio_d = prio_q;
          state_d    = S_RESULT;
        end else begin
          ram_wdata = ram_rdata;
          if (idx_q == '0) begin
            state_d = S_INS_HEAD;
          end else begin
            ram_re    = 1'b1;
            ram_raddr = idx_q - AW'(1);
            idx_d     = idx_q - AW'(1);
          end
        end
      end

      S_INS_HEAD: begin
        ram_we     = 1'b1;
        ram_waddr  = '0;
        ram_wdata  = new_entry;
        count_d    = count_q + CW'(1);
        next_id_d  = id_after;
        res_id_d   = next_id_q;
        res_prio_d = prio_q;
        state_d    = S_RESULT;
      end

      S_DEL: begin
        if (found_q) begin
          // Close the gap: each entry behind the removed one moves up by one.
          ram_we    = 1'b1;
          ram_waddr = idx_q - AW'(1);
          ram_wdata = ram_rdata;
        end else if (id_match) begin
          found_d    = 1'b1;
          res_id_d   = ram_rdata.id;
          res_prio_d = ram_rdata.prio;
        end
        if (idx_q == last_idx) begin
          if (found_q || id_match) begin
            count_d      = count_q - CW'(1);
            res_status_d = spq_pkg::ST_OK;
          end else begin
            res_status_d = spq_pkg::ST_NOT_FOUND;
          end
          state_d = S_RESULT;
        end else begin
          ram_re    = 1'b1;
          ram_raddr = idx_q + AW'(1);
          idx_d     = idx_q + AW'(1);
        end
      end

      S_RESULT: begin
        if (!m_valid_q || m_axis_tready) begin
          m_valid_d  = 1'b1;
          m_status_d = res_status_q;
          m_id_d     = res_id_q;
          m_prio_d   = res_prio_q;
          state_d    = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      count_q   <= '0;
      next_id_q <= IB'(1);
      m_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      count_q   <= count_d;
      next_id_q <= next_id_d;
      m_valid_q <= m_valid_d;
    end
  end

  // Payload registers carry no reset.
  always_ff @(posedge clk_i) begin
    idx_q        <= idx_d;
    found_q      <= found_d;
    is_pop_q     <= is_pop_d;
    prio_q       <= prio_d;
    tid_q        <= tid_d;
    res_status_q <= res_status_d;
    res_id_q     <= res_id_d;
    res_prio_q   <= res_prio_d;
    m_status_q   <= m_status_d;
    m_id_q       <= m_id_d;
    m_prio_q     <= m_prio_d;
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = {{PAD_BITS{1'b0}}, m_prio_q, m_id_q, SB'(m_status_q)};

endmodule
